// ----- src/wtv_pkg.sv -----
// package for the word tokeniser with vocabulary store
// types, character codes and sizing constants; no dependencies
package wtv_pkg;

	localparam int VOCAB_DEPTH_DEF  = 1024;
	localparam int MAX_WORD_LEN_DEF = 32;
	localparam int IDX_W            = 10;
	localparam int LIMIT_W          = 11;

	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_NL    = 8'h0a;
	localparam logic [7:0] CH_DOT   = 8'h2e;
	localparam logic [7:0] CH_BANG  = 8'h21;
	localparam logic [7:0] CH_QUERY = 8'h3f;

	typedef enum logic [1:0] {
		OUT_OK   = 2'd0,
		OUT_FULL = 2'd1,
		OUT_LONG = 2'd2
	} outcome_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_LOOK,
		ST_LEN,
		ST_CMP,
		ST_ADD,
		ST_COPY,
		ST_EMIT,
		ST_WAIT
	} state_t;

	// result handed from sequencer to output register
	typedef struct packed {
		logic [IDX_W-1:0] index;
		outcome_t         outcome;
		logic             last;
	} result_t;

endpackage

// ----- src/wtv_store.sv -----
// vocabulary store: entry bytes and entry lengths memories
// registered reads; uses wtv_pkg
module wtv_store #(
	parameter int VOCAB_DEPTH  = wtv_pkg::VOCAB_DEPTH_DEF,
	parameter int MAX_WORD_LEN = wtv_pkg::MAX_WORD_LEN_DEF,
	localparam int EW = $clog2(VOCAB_DEPTH),
	localparam int BW = $clog2(MAX_WORD_LEN),
	localparam int LW = $clog2(MAX_WORD_LEN + 1)
) (
	input  logic          clk,
	input  logic          len_we,
	input  logic [EW-1:0] len_addr,
	input  logic [LW-1:0] len_wdata,
	output logic [LW-1:0] len_rdata,
	input  logic          byte_we,
	input  logic [EW-1:0] byte_entry,
	input  logic [BW-1:0] byte_pos,
	input  logic [7:0]    byte_wdata,
	output logic [7:0]    byte_rdata
);
	logic [LW-1:0] len_mem [VOCAB_DEPTH];
	logic [7:0]    byte_mem [VOCAB_DEPTH * MAX_WORD_LEN];
	logic [EW+BW-1:0] baddr;

	// flat address of one entry byte
	assign baddr = EW'(byte_entry) * (EW+BW)'(MAX_WORD_LEN) + (EW+BW)'(byte_pos);

	// length memory
	always_ff @(posedge clk) begin
		if (len_we) len_mem[len_addr] <= len_wdata;
		len_rdata <= len_mem[len_addr];
	end

	// byte memory
	always_ff @(posedge clk) begin
		if (byte_we) byte_mem[baddr] <= byte_wdata;
		byte_rdata <= byte_mem[baddr];
	end
endmodule

// ----- src/word_tokenizer_vocabulary.sv -----
// word tokeniser: a word byte is stored while idle; a word end starts a search over the
// stored entries, comparing bytes only where the length matches; a hit emits its index,
// a miss copies the word into a new entry and emits that index
// a mark after a word repeats the search once the word's token has been taken
// the input stalls until the last token of a byte is taken by the receiver
// arst_n clears control state and sets the limit to 1024
module word_tokenizer_vocabulary #(
	parameter int VOCAB_DEPTH  = wtv_pkg::VOCAB_DEPTH_DEF,
	parameter int MAX_WORD_LEN = wtv_pkg::MAX_WORD_LEN_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [wtv_pkg::LIMIT_W-1:0] cfg_data,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [7:0]                  text_byte,
	input  logic                        block_end,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [wtv_pkg::IDX_W-1:0]   token_index,
	output logic [1:0]                  outcome,
	output logic                        run_last
);
	import wtv_pkg::*;

	localparam int EW = $clog2(VOCAB_DEPTH);
	localparam int CW = EW + 1;
	localparam int BW = $clog2(MAX_WORD_LEN);
	localparam int LW = $clog2(MAX_WORD_LEN + 1);

	state_t st_q, st_d;
	logic [LIMIT_W-1:0] limit_q;
	logic [7:0] word_q [MAX_WORD_LEN];
	logic [LW-1:0] wlen_q, wlen_d;
	logic inword_q, inword_d, long_q, long_d, halted_q, halted_d;
	logic [CW-1:0] count_q, count_d;
	logic [EW-1:0] ent_q, ent_d;
	logic [LW-1:0] pos_q, pos_d;
	logic [7:0] mark_q, mark_d;
	logic markp_q, markp_d, sing_q, sing_d;
	result_t res_q, res_d;
	logic ov_q, ov_d;

	logic len_we, byte_we;
	logic [EW-1:0] len_addr, byte_entry;
	logic [BW-1:0] byte_pos;
	logic [LW-1:0] len_wdata, len_rdata;
	logic [7:0] byte_wdata, byte_rdata, cur_byte;
	logic [CW-1:0] cap;
	logic accept, is_sep, is_mark;

	wtv_store #(.VOCAB_DEPTH(VOCAB_DEPTH), .MAX_WORD_LEN(MAX_WORD_LEN)) u_store (
		.clk, .len_we, .len_addr, .len_wdata, .len_rdata,
		.byte_we, .byte_entry, .byte_pos, .byte_wdata, .byte_rdata
	);

	// effective capacity
	assign cap = (32'(limit_q) < 32'(VOCAB_DEPTH)) ? CW'(limit_q) : CW'(VOCAB_DEPTH);

	assign in_stall = (st_q != ST_IDLE) || ov_q;
	assign accept   = in_valid && !in_stall;
	assign is_sep   = text_byte == CH_SPACE || text_byte == CH_NL;
	assign is_mark  = text_byte == CH_DOT || text_byte == CH_BANG || text_byte == CH_QUERY;
	// current word byte (single mark or pending word)
	assign cur_byte = sing_q ? mark_q : word_q[pos_q[BW-1:0]];

	assign out_valid   = ov_q;
	assign token_index = res_q.index;
	assign outcome     = res_q.outcome;
	assign run_last    = res_q.last;

	// state and control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE; limit_q <= LIMIT_W'(1024); wlen_q <= '0;
			inword_q <= 1'b0; long_q <= 1'b0; halted_q <= 1'b0; count_q <= '0;
			ov_q <= 1'b0; markp_q <= 1'b0; sing_q <= 1'b0;
		end else begin
			st_q <= st_d; wlen_q <= wlen_d; inword_q <= inword_d; long_q <= long_d;
			halted_q <= halted_d; count_q <= count_d; ov_q <= ov_d;
			markp_q <= markp_d; sing_q <= sing_d;
			if (cfg_we) limit_q <= cfg_data;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		ent_q <= ent_d; pos_q <= pos_d; mark_q <= mark_d; res_q <= res_d;
		if (accept && !halted_q && !is_sep && !is_mark && wlen_q < LW'(MAX_WORD_LEN))
			word_q[wlen_q[BW-1:0]] <= text_byte;
	end

	// sequencer
	always_comb begin
		logic [LW-1:0] ulen;
		ulen = sing_q ? LW'(1) : wlen_q;
		st_d = st_q; wlen_d = wlen_q; inword_d = inword_q; long_d = long_q;
		halted_d = halted_q; count_d = count_q; ent_d = ent_q; pos_d = pos_q;
		mark_d = mark_q; markp_d = markp_q; sing_d = sing_q;
		res_d = res_q; ov_d = ov_q && out_stall;
		len_we = 1'b0; byte_we = 1'b0; len_addr = ent_q; byte_entry = ent_q;
		byte_pos = pos_q[BW-1:0]; len_wdata = ulen; byte_wdata = cur_byte;
		unique case (st_q)
			ST_IDLE: begin
				if (accept && !halted_q) begin
					mark_d = text_byte; sing_d = 1'b0;
					markp_d = is_mark;
					if ((is_sep || is_mark) && inword_q) begin
						st_d = ST_LOOK;
					end else if (!is_sep && !is_mark) begin
						if (!inword_q) begin
							inword_d = 1'b1; long_d = 1'b0;
						end
						if (!inword_q) wlen_d = LW'(1);
						else if (wlen_q < LW'(MAX_WORD_LEN)) wlen_d = wlen_q + 1'b1;
						else long_d = 1'b1;
						if (block_end) begin
							inword_d = 1'b0; wlen_d = '0; long_d = 1'b0;
							st_d = ST_IDLE;
						end
					end
				end
			end
			ST_LOOK: begin
				// mark search waits until the word's token is taken
				if (!(ov_q && out_stall)) begin
					ent_d = '0; pos_d = '0;
					if (!sing_q && long_q) begin
						res_d = '{index: '0, outcome: OUT_LONG, last: !markp_q};
						st_d = ST_EMIT;
					end else if (count_q == '0) begin
						st_d = ST_ADD;
					end else begin
						len_addr = '0; st_d = ST_LEN;
					end
				end
			end
			ST_LEN: begin
				// length memory read is now valid; start byte read
				byte_pos = '0;
				if (len_rdata == ulen) begin
					st_d = ST_CMP;
				end else if (CW'(ent_q) + 1'b1 >= count_q) begin
					st_d = ST_ADD;
				end else begin
					ent_d = ent_q + 1'b1; len_addr = ent_q + 1'b1;
					st_d = ST_WAIT;
				end
			end
			ST_WAIT: begin
				len_addr = ent_q; byte_pos = '0; pos_d = '0; st_d = ST_LEN;
			end
			ST_CMP: begin
				// byte at pos_q read registered here
				if (pos_q == ulen) begin
					res_d = '{index: IDX_W'(ent_q), outcome: OUT_OK,
						last: sing_q || !markp_q};
					st_d = ST_EMIT;
				end else if (byte_rdata != cur_byte) begin
					pos_d = '0;
					if (CW'(ent_q) + 1'b1 >= count_q) st_d = ST_ADD;
					else begin
						ent_d = ent_q + 1'b1; st_d = ST_WAIT;
					end
				end else begin
					pos_d = pos_q + 1'b1; byte_pos = BW'(pos_q + 1'b1);
					if (pos_q + 1'b1 == ulen) byte_pos = '0;
					st_d = ST_CMP;
				end
			end
			ST_ADD: begin
				if (count_q >= cap) begin
					res_d = '{index: '0, outcome: OUT_FULL, last: 1'b1};
					halted_d = 1'b1; markp_d = 1'b0; st_d = ST_EMIT;
				end else begin
					ent_d = EW'(count_q); pos_d = '0;
					byte_entry = EW'(count_q); len_addr = EW'(count_q);
					len_we = 1'b1; st_d = ST_COPY;
				end
			end
			ST_COPY: begin
				// copy word bytes into the new entry one a cycle
				if (pos_q == ulen) begin
					count_d = count_q + 1'b1;
					res_d = '{index: IDX_W'(ent_q), outcome: OUT_OK,
						last: sing_q || !markp_q};
					st_d = ST_EMIT;
				end else begin
					byte_we = 1'b1; pos_d = pos_q + 1'b1;
				end
			end
			ST_EMIT: begin
				if (!ov_q || !out_stall) begin
					ov_d = 1'b1;
					if (!sing_q && markp_q && !halted_q) begin
						sing_d = 1'b1; st_d = ST_LOOK;
					end else begin
						sing_d = 1'b0; inword_d = 1'b0; wlen_d = '0; long_d = 1'b0;
						st_d = ST_IDLE;
					end
					if (!sing_q) begin
						inword_d = 1'b0; wlen_d = '0; long_d = 1'b0;
					end
				end
			end
			default: st_d = ST_IDLE;
		endcase
	end
endmodule

// ----- tb/testbench.sv -----
// testbench for the word tokeniser with vocabulary store
// drives bytes, predicts token words and checks them; depends on wtv_pkg and the block
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import wtv_pkg::*;

	localparam int DEPTH   = VOCAB_DEPTH_DEF;
	localparam int WLEN    = MAX_WORD_LEN_DEF;
	localparam int WDOG    = 400000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [LIMIT_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [7:0] text_byte = '0;
	logic block_end = 1'b0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [IDX_W-1:0] token_index;
	logic [1:0] outcome;
	logic run_last;

	typedef struct packed {
		logic [IDX_W-1:0] index;
		logic [1:0]       code;
		logic             last;
	} token_t;

	// predictor state
	logic [7:0] pend_bytes [WLEN];
	int         pend_len;
	bit         in_word;
	bit         overlong;
	logic [7:0] vocab_bytes [DEPTH][WLEN];
	int         vocab_len [DEPTH];
	int         vocab_count;
	bit         stopped;
	int         limit_reg;

	token_t tokens_due[$];
	int     fails = 0;
	int     idle_cycles = 0;
	int     stall_left = 0;
	bit     calm = 1'b0;

	word_tokenizer_vocabulary DUT (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall), .text_byte(text_byte),
		.block_end(block_end), .out_valid(out_valid), .out_stall(out_stall),
		.token_index(token_index), .outcome(outcome), .run_last(run_last)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic void vocab_clear();
		pend_len = 0;
		in_word = 0;
		overlong = 0;
		vocab_count = 0;
		stopped = 0;
		limit_reg = 1024;
	endfunction

	// look up or append an entry; returns 1 when the vocabulary is full
	function automatic bit vocab_lookup(input logic [7:0] w [WLEN], input int n,
			output int idx);
		int cap;
		bit same;
		for (int i = 0; i < vocab_count; i++) begin
			if (vocab_len[i] == n) begin
				same = 1;
				for (int k = 0; k < n; k++)
					if (vocab_bytes[i][k] != w[k]) same = 0;
				if (same) begin
					idx = i;
					return 0;
				end
			end
		end
		cap = (limit_reg < DEPTH) ? limit_reg : DEPTH;
		if (vocab_count >= cap) return 1;
		for (int k = 0; k < n; k++) vocab_bytes[vocab_count][k] = w[k];
		vocab_len[vocab_count] = n;
		idx = vocab_count;
		vocab_count++;
		return 0;
	endfunction

	function automatic void push_token(ref token_t got[$], input int idx, input logic [1:0] c);
		token_t t;
		t.index = idx[IDX_W-1:0];
		t.code = c;
		t.last = 0;
		got.push_back(t);
	endfunction

	function automatic void close_word(ref token_t got[$]);
		int idx;
		if (overlong) push_token(got, 0, OUT_LONG);
		else if (vocab_lookup(pend_bytes, pend_len, idx)) begin
			push_token(got, 0, OUT_FULL);
			stopped = 1;
		end else push_token(got, idx, OUT_OK);
		in_word = 0;
		pend_len = 0;
		overlong = 0;
	endfunction

	// expected tokens for one accepted byte
	function automatic void tokenise_byte(input logic [7:0] b, input bit fin,
			ref token_t got[$]);
		logic [7:0] mark [WLEN];
		int idx;
		if (stopped) return;
		if (b == CH_SPACE || b == CH_NL) begin
			if (in_word) close_word(got);
		end else if (b == CH_DOT || b == CH_BANG || b == CH_QUERY) begin
			if (in_word) begin
				close_word(got);
				if (!stopped) begin
					mark[0] = b;
					if (vocab_lookup(mark, 1, idx)) begin
						push_token(got, 0, OUT_FULL);
						stopped = 1;
					end else push_token(got, idx, OUT_OK);
				end
			end
		end else begin
			if (!in_word) begin
				in_word = 1;
				pend_len = 0;
				overlong = 0;
			end
			if (pend_len < WLEN) begin
				pend_bytes[pend_len] = b;
				pend_len++;
			end else overlong = 1;
		end
		if (fin) begin
			in_word = 0;
			pend_len = 0;
			overlong = 0;
		end
		if (got.size() > 0) got[got.size()-1].last = 1;
	endfunction

	// send one byte; optional fixed expectation is checked against the predictor
	task automatic send_byte(input logic [7:0] b, input bit fin, input int want = -1,
			input logic [1:0] want_code = OUT_OK);
		token_t got[$];
		while (!calm && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 15)) @(posedge clk);
		end
		in_valid <= 1'b1;
		text_byte <= b;
		block_end <= fin;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		tokenise_byte(b, fin, got);
		if (want >= 0 && (got.size() == 0 || got[0].index != want[IDX_W-1:0]
				|| got[0].code != want_code)) begin
			fails++;
			if (fails <= 10)
				$display("table row mismatch on byte %h: predicted %p", b, got);
		end
		foreach (got[i]) tokens_due.push_back(got[i]);
	endtask

	task automatic drain();
		int n;
		n = 0;
		in_valid <= 1'b0;
		while (tokens_due.size() > 0) @(posedge clk);
		while (n < 3 * DEPTH * WLEN) begin
			@(posedge clk);
			n++;
		end
	endtask

	task automatic write_limit(input int v);
		cfg_we <= 1'b1;
		cfg_data <= v[LIMIT_W-1:0];
		@(posedge clk);
		cfg_we <= 1'b0;
		limit_reg = v & 11'h7ff;
		@(posedge clk);
	endtask

	task automatic send_word(input int len);
		logic [7:0] c;
		for (int i = 0; i < len; i++) begin
			c = 8'h61 + 8'($urandom_range(0, 3));
			send_byte(c, 0);
		end
	endtask

	function automatic logic [7:0] pick_sep();
		case ($urandom_range(0, 4))
			0: return CH_SPACE;
			1: return CH_NL;
			2: return CH_DOT;
			3: return CH_BANG;
			default: return CH_QUERY;
		endcase
	endfunction

	// receiving side: stall bursts and word checks
	always @(posedge clk) begin
		token_t want;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (tokens_due.size() == 0) begin
					fails++;
					if (fails <= 10) $display("unexpected token idx=%0d code=%0d",
						token_index, outcome);
				end else begin
					want = tokens_due.pop_front();
					if (want.index !== token_index || want.code !== outcome ||
							want.last !== run_last) begin
						fails++;
						if (fails <= 10)
							$display("mismatch exp %0d/%0d/%0d got %0d/%0d/%0d",
								want.index, want.code, want.last,
								token_index, outcome, run_last);
					end
				end
			end
			// stall bursts, started at random while not calm
			if (stall_left > 0) begin
				stall_left <= stall_left - 1;
				if (stall_left == 1) out_stall <= 1'b0;
			end else if (!calm && $urandom_range(0, 7) == 0) begin
				stall_left <= int'($urandom_range(1, 15));
				out_stall <= 1'b1;
			end
		end
	end

	// watchdog on cycles without any accepted byte or taken token
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles > WDOG) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	// directed table: byte, block end, fixed index (-1 when predicted), code
	typedef struct { logic [7:0] b; bit fin; int want; logic [1:0] code; } row_t;
	row_t rows [] = '{
		'{8'h00, 0, -1, OUT_OK}, '{CH_SPACE, 0, 0, OUT_OK},
		'{8'hff, 0, -1, OUT_OK}, '{CH_DOT, 0, 1, OUT_OK},
		'{CH_DOT, 0, -1, OUT_OK}, '{8'h41, 0, -1, OUT_OK},
		'{CH_BANG, 0, 3, OUT_OK}, '{8'h41, 0, -1, OUT_OK},
		'{CH_QUERY, 0, 3, OUT_OK}, '{8'h42, 0, -1, OUT_OK},
		'{CH_NL, 0, -1, OUT_OK}, '{8'h43, 1, -1, OUT_OK},
		'{CH_SPACE, 0, -1, OUT_OK}, '{8'h00, 0, -1, OUT_OK},
		'{CH_NL, 0, 0, OUT_OK}, '{8'h44, 0, -1, OUT_OK},
		'{CH_DOT, 1, -1, OUT_OK}, '{8'haa, 0, -1, OUT_OK},
		'{8'h55, 0, -1, OUT_OK}, '{CH_SPACE, 0, -1, OUT_OK}
	};

	initial begin
		int len;
		vocab_clear();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		write_limit(DEPTH);
		foreach (rows[i]) send_byte(rows[i].b, rows[i].fin, rows[i].want, rows[i].code);
		// overlong word, then one of exact maximum length
		for (int i = 0; i < WLEN + 3; i++) send_byte(8'h7a, 0);
		send_byte(CH_DOT, 0, 0, OUT_LONG);
		send_word(WLEN);
		send_byte(CH_SPACE, 0);
		// random text under the full limit
		for (int n = 0; n < 100; n++) begin
			len = ($urandom_range(0, 30) == 0) ? $urandom_range(30, 36)
				: $urandom_range(1, 4);
			if ($urandom_range(0, 9) == 0) begin
				send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 5) == 0);
			end else begin
				send_word(len);
				send_byte(pick_sep(), $urandom_range(0, 12) == 0);
			end
			if (n > 80) calm = 1;
		end
		drain();
		// small limit runs into a full halt; then stays silent
		write_limit(vocab_count + 3);
		for (int n = 0; n < 40; n++) begin
			send_byte(8'h30 + n[7:0], 0);
			send_byte(pick_sep(), 0);
		end
		drain();
		write_limit(0);
		write_limit(2047);
		send_byte(8'h80, 0);
		send_byte(CH_SPACE, 0);
		calm = 1;
		drain();
		if (fails == 0) $display("== PASS ==");
		else $display("== FAIL ==");
		$finish;
	end
endmodule
